### rtl/red_pkg.sv
// ----------------------------------------------------------------------------
// red_pkg
// Types and constants shared by the replica exchange decision block.
// ----------------------------------------------------------------------------
`default_nettype none
package red_pkg;
  localparam int NUM_SLOTS_DEF = 8;
  localparam int SLOT_CAP      = 8;
  localparam int BETA_W        = 16;
  localparam int ENERGY_W      = 32;
  localparam int COUNT_W       = 32;
  localparam int REP_W         = 3;
  localparam int IDX_W         = 3;
  localparam logic [15:0] BETA_RESET = 16'd4096;
  localparam logic [49:0] UNDERFLOW_T = 50'd49152;

  typedef struct packed {
    logic [2:0]  slot_index;
    logic [15:0] uniform_fraction;
    logic signed [31:0] energy_lower;
    logic signed [31:0] energy_upper;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  exchanged_slot;
    logic        accepted;
    logic [2:0]  replica_lower;
    logic [2:0]  replica_upper;
    logic [31:0] count_value;
  } out_item_t;

  // reciprocal of j in Q1.32, rounded up: floor(v*R>>32) is exact for the
  // Horner operand, which stays below 3*2^28 (t < 49152, acc <= 2^30)
  function automatic logic [32:0] recip(input logic [3:0] j);
    logic [32:0] r;
    r = 33'd0;
    case (j)
      4'd1:  r = 33'h1_0000_0000;
      4'd2:  r = 33'h0_8000_0000;
      4'd3:  r = 33'h0_5555_5556;
      4'd4:  r = 33'h0_4000_0000;
      4'd5:  r = 33'h0_3333_3334;
      4'd6:  r = 33'h0_2AAA_AAAB;
      4'd7:  r = 33'h0_2492_4925;
      4'd8:  r = 33'h0_2000_0000;
      4'd9:  r = 33'h0_1C71_C71D;
      4'd10: r = 33'h0_1999_999A;
      default: r = 33'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

### rtl/replica_exchange_decision.sv
// ----------------------------------------------------------------------------
// replica_exchange_decision
// Parallel tempering exchange decision: exponent, Metropolis test, swap, count.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | payload
// in_     | in  | in_valid/in_stall  | red_pkg::in_item_t
// out_    | out | out_valid/out_stall| red_pkg::out_item_t
// cfg_    | in  | cfg_we             | cfg_index, cfg_data
// Full path: a bit-serial |db|*|de| product, a sign/underflow check, Horner
// (multiply, then reciprocal divide, per term), 4 squarings and a commit. With
// no exp needed (x >= 0 or underflow) Horner and squarings are skipped; a bad
// slot skips the product and the check as well.
// Reset is synchronous; no clearing pass. The input stalls while an item is
// in flight or the result waits, so only one item is handled at a time.
`default_nettype none
module replica_exchange_decision #(
  parameter int NUM_SLOTS = red_pkg::NUM_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire red_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output red_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_MUL = 7'b0000010, S_SIGN = 7'b0000100,
    S_HRN = 7'b0001000, S_SQR = 7'b0010000, S_FIN = 7'b0100000,
    S_OUT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] beta_r [red_pkg::SLOT_CAP];
  logic [2:0]  rep_r  [red_pkg::SLOT_CAP];
  logic [31:0] cnt_r  [red_pkg::SLOT_CAP];
  red_pkg::in_item_t item_r;
  red_pkg::out_item_t res_r;
  logic        ok_r;     // slot index in range
  logic [16:0] mcand_r;  // |db| shifted right one bit per cycle
  logic [49:0] prod_r;   // |db|*|de| accumulator
  logic [47:0] de_r;     // |de|, shifted left
  logic        neg_r;    // x sign
  logic [4:0]  bit_r;
  logic [3:0]  j_r;
  logic [1:0]  sq_r;
  logic [1:0]  ph_r;     // multiply phase within an exp step
  logic [30:0] acc_r;
  logic [63:0] mp_r;
  logic        acc_ok_r;

  logic [2:0] k, km1;
  logic signed [16:0] db;
  logic signed [32:0] de;
  assign k   = item_r.slot_index;
  assign km1 = k - 3'd1;
  assign db  = $signed({1'b0, beta_r[km1]}) - $signed({1'b0, beta_r[k]});
  assign de  = $signed({item_r.energy_lower[31], item_r.energy_lower}) -
               $signed({item_r.energy_upper[31], item_r.energy_upper});

  logic [15:0] zt;
  assign zt = prod_r[15:0];

  logic [31:0] mul_a;
  logic [32:0] mul_b;
  logic [63:0] mul_p;
  assign mul_p = 64'(mul_a * mul_b);

  logic [30:0] fin_e;
  logic [16:0] e16;
  assign e16   = 17'((acc_r + 31'd8192) >> 14);
  assign fin_e = {14'd0, (e16 > 17'd65535) ? 17'd65535 : e16};

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = res_r;

  always_comb begin
    mul_a = 32'd0;
    mul_b = 33'd0;
    case (state_r)
      S_HRN: begin
        if (ph_r == 2'd0) begin
          mul_a = {16'd0, zt};
          mul_b = {2'd0, acc_r};
        end else begin
          mul_a = mp_r[47:16];
          mul_b = red_pkg::recip(j_r);
        end
      end
      S_SQR: begin
        mul_a = {1'b0, acc_r};
        mul_b = {2'd0, acc_r};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_MUL;
      S_MUL:  if (!ok_r || bit_r == 5'd16) state_nxt = ok_r ? S_SIGN : S_FIN;
      S_SIGN: state_nxt = (!neg_r || prod_r == 50'd0 || prod_r >= red_pkg::UNDERFLOW_T)
                          ? S_FIN : S_HRN;
      S_HRN:  if (ph_r == 2'd1 && j_r == 4'd1) state_nxt = S_SQR;
      S_SQR:  if (sq_r == 2'd3) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic accept;
  always_comb begin
    accept = 1'b0;
    if (ok_r) begin
      if (!neg_r || prod_r == 50'd0) accept = 1'b1;
      else if (acc_ok_r) accept = ({15'd0, item_r.uniform_fraction} < fin_e);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < red_pkg::SLOT_CAP; i++) begin
        beta_r[i] <= red_pkg::BETA_RESET;
        rep_r[i]  <= 3'(i);
        cnt_r[i]  <= 32'd0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) beta_r[cfg_index] <= cfg_data;
      case (state_r)
        S_IDLE: if (in_valid) begin
          item_r <= in_data;
          ok_r   <= (in_data.slot_index != 3'd0) &&
                    ({29'd0, in_data.slot_index} < 32'(NUM_SLOTS));
          bit_r  <= 5'd0;
          prod_r <= 50'd0;
        end
        S_MUL: begin
          if (bit_r == 5'd0) begin
            mcand_r <= db[16] ? 17'(-db) : 17'(db);
            de_r    <= {15'd0, de[32] ? 33'(-de) : 33'(de)};
            neg_r   <= db[16] ^ de[32];
            bit_r   <= 5'd1;
          end else begin
            // one multiplier bit per cycle
            if (mcand_r[0]) prod_r <= prod_r + {2'd0, de_r};
            de_r    <= de_r << 1;
            mcand_r <= mcand_r >> 1;
            bit_r   <= bit_r + 5'd1;
          end
        end
        S_SIGN: begin
          acc_r    <= 31'h4000_0000;
          j_r      <= 4'd10;
          ph_r     <= 2'd0;
          sq_r     <= 2'd0;
          acc_ok_r <= !(prod_r >= red_pkg::UNDERFLOW_T);
        end
        S_HRN: begin
          if (ph_r == 2'd0) begin
            mp_r <= mul_p;
            ph_r <= 2'd1;
          end else begin
            acc_r <= 31'h4000_0000 - 31'(mul_p[63:32]);
            j_r   <= j_r - 4'd1;
            ph_r  <= 2'd0;
          end
        end
        S_SQR: begin
          acc_r <= 31'((mul_p + 64'h2000_0000) >> 30);
          sq_r  <= sq_r + 2'd1;
        end
        S_FIN: begin
          res_r.accepted       <= accept;
          res_r.exchanged_slot <= accept ? k : 3'd0;
          if (!ok_r) begin
            res_r.replica_lower <= 3'd0;
            res_r.replica_upper <= 3'd0;
          end else if (accept) begin
            res_r.replica_lower <= rep_r[k];
            res_r.replica_upper <= rep_r[km1];
            rep_r[km1] <= rep_r[k];
            rep_r[k]   <= rep_r[km1];
          end else begin
            res_r.replica_lower <= rep_r[km1];
            res_r.replica_upper <= rep_r[k];
          end
          if (accept) begin
            if (cnt_r[k] != 32'hFFFF_FFFF) cnt_r[k] <= cnt_r[k] + 32'd1;
            res_r.count_value <= (cnt_r[k] != 32'hFFFF_FFFF) ? cnt_r[k] + 32'd1 : cnt_r[k];
          end else begin
            if (cnt_r[0] != 32'hFFFF_FFFF) cnt_r[0] <= cnt_r[0] + 32'd1;
            res_r.count_value <= (cnt_r[0] != 32'hFFFF_FFFF) ? cnt_r[0] + 32'd1 : cnt_r[0];
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/red_checker.sv
// ----------------------------------------------------------------------------
// red_checker
// Port-level checks for the replica exchange decision block.
// ----------------------------------------------------------------------------
`default_nettype none
module red_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire red_pkg::out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  a_acc_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.accepted == (out_data.exchanged_slot != 3'd0)))
    else $error("accepted flag and slot disagree");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
  a_cnt_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.count_value != 32'd0)
    else $error("counter result is zero");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transfer");
endmodule

bind replica_exchange_decision red_checker u_red_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

### test/replica_exchange_decision_tb.sv
// ----------------------------------------------------------------------------
// replica_exchange_decision_tb
// Drives exchange attempts with bursty valid and random output stall, predicts
// each decision, swap and counter value, and compares every result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module replica_exchange_decision_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  red_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  red_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  replica_exchange_decision u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [15:0] beta_q[8];
  logic [2:0]  slot_rep[8];
  logic [31:0] swap_cnt[8];

  red_pkg::in_item_t  attempt_q[$];
  red_pkg::out_item_t decision_q[$];
  int errors = 0;
  int n_acc = 0;
  int n_rej = 0;
  int n_sent = 0;
  bit hold_out = 1'b0;
  bit feed_on = 1'b1;

  function automatic logic [15:0] exp_neg(input logic [63:0] t);
    logic [63:0] a;
    if (t >= 64'd49152) return 16'd0;
    a = 64'd1 << 30;
    for (int j = 10; j >= 1; j--)
      a = (64'd1 << 30) - ((t * a) >> 16) / j;
    for (int s = 0; s < 4; s++)
      a = (a * a + (64'd1 << 29)) >> 30;
    a = (a + (64'd1 << 13)) >> 14;
    if (a > 64'd65535) a = 64'd65535;
    return a[15:0];
  endfunction

  function automatic logic [31:0] bump_cnt(input int i);
    if (swap_cnt[i] != 32'hFFFF_FFFF) swap_cnt[i] = swap_cnt[i] + 1;
    return swap_cnt[i];
  endfunction

  function automatic red_pkg::out_item_t decide(input red_pkg::in_item_t it);
    red_pkg::out_item_t r;
    int k;
    logic signed [63:0] db, de, x;
    logic [2:0] tmp;
    bit acc;
    r = '0;
    k = it.slot_index;
    if (k == 0) begin
      r.count_value = bump_cnt(0);
      return r;
    end
    db = $signed({48'd0, beta_q[k-1]}) - $signed({48'd0, beta_q[k]});
    de = 64'(it.energy_lower) - 64'(it.energy_upper);
    x = db * de;
    if (x >= 0) acc = 1'b1;
    else acc = it.uniform_fraction < exp_neg(64'(-x));
    if (acc) begin
      tmp = slot_rep[k-1];
      slot_rep[k-1] = slot_rep[k];
      slot_rep[k] = tmp;
      r.count_value = bump_cnt(k);
      r.exchanged_slot = 3'(k);
      r.accepted = 1'b1;
    end else begin
      r.count_value = bump_cnt(0);
    end
    r.replica_lower = slot_rep[k-1];
    r.replica_upper = slot_rep[k];
    return r;
  endfunction

  // driver: bursts and gaps; the offered item is always the head of attempt_q
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        n_sent <= n_sent + 1;
        decision_q = {decision_q, decide(in_data)};
        void'(attempt_q.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (feed_on && attempt_q.size() > 0) begin
          in_data <= attempt_q[0];
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 8);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (decision_q.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          red_pkg::out_item_t e;
          e = decision_q.pop_front();
          if (out_data.exchanged_slot !== e.exchanged_slot) begin
            $error("exchanged_slot exp %0d got %0d", e.exchanged_slot, out_data.exchanged_slot);
            errors++;
          end
          if (out_data.accepted !== e.accepted) begin
            $error("accepted exp %0d got %0d", e.accepted, out_data.accepted);
            errors++;
          end
          if (out_data.replica_lower !== e.replica_lower) begin
            $error("replica_lower exp %0d got %0d", e.replica_lower, out_data.replica_lower);
            errors++;
          end
          if (out_data.replica_upper !== e.replica_upper) begin
            $error("replica_upper exp %0d got %0d", e.replica_upper, out_data.replica_upper);
            errors++;
          end
          if (out_data.count_value !== e.count_value) begin
            $error("count_value exp %0d got %0d", e.count_value, out_data.count_value);
            errors++;
          end
          if (e.accepted) n_acc++;
          else n_rej++;
        end
      end
      if (hold_out) out_stall <= 1'b1;
      else if ($urandom_range(0, 199) < 3) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 9) < 3);
    end
  end

  task automatic wait_drained();
    while (attempt_q.size() != 0 || in_valid || decision_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_beta(input int idx, input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= 3'(idx);
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    beta_q[idx] = v;
  endtask

  function automatic red_pkg::in_item_t rand_attempt();
    red_pkg::in_item_t a;
    int m;
    a.slot_index = ($urandom_range(0, 19) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
    a.uniform_fraction = 16'($urandom);
    m = $urandom_range(0, 3);
    a.energy_lower = $urandom;
    if (m == 0) a.energy_upper = $urandom;
    else a.energy_upper = a.energy_lower + $signed(32'($urandom_range(0, 24))) - 12;
    return a;
  endfunction

  task automatic add_attempt(input logic [2:0] k, input logic [15:0] u,
                             input logic [31:0] el, input logic [31:0] eu);
    red_pkg::in_item_t a;
    a.slot_index = k;
    a.uniform_fraction = u;
    a.energy_lower = el;
    a.energy_upper = eu;
    attempt_q = {attempt_q, a};
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      beta_q[i] = red_pkg::BETA_RESET;
      slot_rep[i] = 3'(i);
      swap_cnt[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // directed: equal betas (x = 0), extremes, invalid slot
    add_attempt(3'd1, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    add_attempt(3'd7, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF);
    add_attempt(3'd0, 16'h1234, 32'd5, 32'd3);
    wait_drained();
    // graded betas so that exponent signs and magnitudes vary
    for (int i = 0; i < 8; i++) write_beta(i, 16'(1024 + i * 512));
    write_beta(0, 16'hFFFF);
    write_beta(1, 16'h0000);
    add_attempt(3'd1, 16'h0000, 32'd10, 32'd0);
    add_attempt(3'd1, 16'hFFFF, 32'd0, 32'd1);
    add_attempt(3'd1, 16'h0000, 32'd0, 32'd1);
    add_attempt(3'd1, 16'h0000, 32'd0, 32'd12);
    add_attempt(3'd1, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF);
    for (int k = 2; k < 8; k++) begin
      add_attempt(3'(k), 16'h8000, 32'd0, 32'd3);
      add_attempt(3'(k), 16'h0001, 32'd0, 32'd40);
      add_attempt(3'(k), 16'h4000, 32'd7, 32'd0);
    end
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < 8; i++)
        write_beta(i, (ph == 3) ? 16'($urandom) : 16'(4096 + $urandom_range(0, 4096) - 2048));
      for (int n = 0; n < 160; n++) attempt_q = {attempt_q, rand_attempt()};
      if (ph == 1) begin
        // long receiver hold-off while sender keeps offering
        hold_out = 1'b1;
        repeat (600) @(posedge clk);
        hold_out = 1'b0;
      end
      if (ph == 2) begin
        repeat (200) @(posedge clk);
        feed_on = 1'b0;
        while (decision_q.size() != 0 || in_valid) @(posedge clk);
        feed_on = 1'b1;
      end
      wait_drained();
    end
    $display("covered %0d attempts: %0d swaps, %0d rejections, 6 beta settings",
             n_sent, n_acc, n_rej);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
